// ===== hdl/isaac_pkg.sv =====
// ============================================================================
// isaac_pkg
// Shared types, constants and mixing functions for the ISAAC generator.
// ============================================================================
package isaac_pkg;

    // Eight-word mixing vector
    typedef logic [7:0][31:0] t_vec;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_RESEED = 2'd0,
        ACT_RAW    = 2'd1,
        ACT_RANGE  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    // One line of the eight-word scramble: v[s] ^= shift(v[s+1]);
    // v[s+3] += v[s]; v[s+1] += v[s+2]  (indices modulo 8)
    function automatic t_vec scramble_step(input t_vec v, input logic [2:0] s);
        t_vec        r;
        logic [31:0] nb;
        logic [31:0] sh;
        r  = v;
        nb = v[s + 3'd1];
        unique case (s)
            3'd0: sh = nb << 11;
            3'd1: sh = nb >> 2;
            3'd2: sh = nb << 8;
            3'd3: sh = nb >> 16;
            3'd4: sh = nb << 10;
            3'd5: sh = nb >> 4;
            3'd6: sh = nb << 8;
            default: sh = nb >> 9;
        endcase
        r[s]         = v[s] ^ sh;
        r[s + 3'd3]  = v[s + 3'd3] + r[s];
        r[s + 3'd1]  = v[s + 3'd1] + v[s + 3'd2];
        return r;
    endfunction

    // Golden-ratio words after four full scrambles
    function automatic t_vec init_vec();
        t_vec r;
        for (int k = 0; k < 8; k++) begin
            r[k] = GOLDEN;
        end
        for (int n = 0; n < 32; n++) begin
            r = scramble_step(r, 3'(n));
        end
        return r;
    endfunction

    localparam t_vec INIT_V = init_vec();

endpackage

// ===== hdl/isaac_random_generator.sv =====
// ============================================================================
// isaac_random_generator
// ISAAC 32-bit generator with buffered output and ranged draws.
// ============================================================================
// One request transaction enters on the s_axis group; its kind is in tuser
// (0 reseed, 1 raw word, 2 word folded into [lower, upper], 3 ignored).
// Draws give one result transaction on m_axis; reseed and kind 3 give none.
// A draw before the first reseed returns word 0 with the tuser flag set.
// Pool and result buffer live in two synchronous single-port-write RAMs.
// Sequence per request:
//   raw draw from the buffer: the buffer word is read and registered,
//     then loaded into the result register.
//   buffer refill (every 2^POOL_LOG2 draws): paced by the pool RAM read
//     port that each ISAAC step uses four times.
//   reseed: two pool passes over eight-word groups (seed words added in
//     the first, pool words in the second) plus one refill.
//   ranged draw: each fold iteration runs the bit-serial divider.
// A request is taken only while the engine is idle; a finished result
// waits in the output register, so one request may be taken while the
// receiver stalls. Reset clears the counters and the seeded flag; the
// RAM contents stay undefined until the first reseed.
// ============================================================================
module isaac_random_generator #(
    parameter int POOL_LOG2 = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] seed_value, [63:32] lower_bound, [95:64] upper_bound
    input  logic [95:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] random_word
    output logic [31:0] m_axis_tdata,
    // [0] not_seeded
    output logic        m_axis_tuser
);
    import isaac_pkg::*;

    localparam int L = POOL_LOG2;
    localparam int N = 1 << L;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MIX, S_WRITE, S_BATCH,
        S_DRAW_RD, S_DRAW_DATA, S_FOLD, S_FCHK, S_DIV, S_RESULT
    } t_state;

    t_state        r_state;
    logic [2:0]    r_ph;
    logic [3:0]    r_k;
    logic          r_pass;
    logic [L-1:0]  r_base;
    logic [L-1:0]  r_i;
    t_vec          r_v;
    logic [31:0]   r_a, r_b, r_cnt;
    logic [31:0]   r_x, r_y;
    logic          r_fwd;
    logic [L:0]    r_rem;
    logic          r_seeded;
    t_action       r_act;
    logic [31:0]   r_seed, r_lo, r_hi;
    logic [31:0]   r_w, r_span, r_q, r_r, r_dv;
    logic [4:0]    r_dcnt;
    logic          r_ns;
    logic          r_ovalid, r_ons;
    logic [31:0]   r_oword;

    // Memories
    logic [31:0]   pool_mem [N];
    logic [31:0]   rbuf_mem [N];
    logic [31:0]   r_pool_q, r_rbuf_q;

    logic          p_we;
    logic [L-1:0]  p_waddr, p_raddr;
    logic [31:0]   p_wdata;
    logic          b_we;
    logic [31:0]   n_y, n_b, n_amix;
    logic [L-1:0]  y_idx;
    logic [32:0]   div_rr;
    logic [31:0]   n_span;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oword;
    assign m_axis_tuser  = r_ons;

    // ISAAC step datapath
    always_comb begin
        unique case (r_i[1:0])
            2'd0: n_amix = r_a ^ (r_a << 13);
            2'd1: n_amix = r_a ^ (r_a >> 6);
            2'd2: n_amix = r_a ^ (r_a << 2);
            default: n_amix = r_a ^ (r_a >> 16);
        endcase
        n_y    = r_pool_q + r_a + r_b;
        y_idx  = n_y[2*L+1:L+2];
        n_b    = (r_fwd ? r_y : r_pool_q) + r_x;
        div_rr = {r_r, r_dv[31]};
        n_span = r_hi - r_lo + 32'd1;
    end

    // Pool and buffer port control
    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_i;
        p_wdata = n_y;
        p_raddr = r_i;
        b_we    = 1'b0;
        unique case (r_state)
            S_WRITE: begin
                p_we    = 1'b1;
                p_waddr = r_base + L'(r_k[2:0]);
                p_wdata = r_v[r_k[2:0]];
            end
            S_LOAD: begin
                p_raddr = r_base + L'(r_k[2:0]);
            end
            S_BATCH: begin
                unique case (r_ph)
                    3'd1: p_raddr = r_i + L'(N / 2);
                    3'd2: p_raddr = r_x[L+1:2];
                    3'd3: begin
                        p_we    = 1'b1;
                        p_raddr = y_idx;
                    end
                    3'd4: b_we = 1'b1;
                    default: p_raddr = r_i;
                endcase
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            pool_mem[p_waddr] <= p_wdata;
        end
        r_pool_q <= pool_mem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            rbuf_mem[r_i] <= n_b;
        end
        r_rbuf_q <= rbuf_mem[r_rem[L-1:0]];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= '0;
            r_k      <= '0;
            r_pass   <= 1'b0;
            r_base   <= '0;
            r_i      <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_cnt    <= '0;
            r_rem    <= '0;
            r_seeded <= 1'b0;
            r_ovalid <= 1'b0;
            r_act    <= ACT_NONE;
            r_dcnt   <= '0;
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (r_ovalid && m_axis_tready && r_state != S_RESULT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_act  <= t_action'(s_axis_tuser);
                        r_seed <= s_axis_tdata[31:0];
                        r_lo   <= s_axis_tdata[63:32];
                        r_hi   <= s_axis_tdata[95:64];
                        r_ns   <= !r_seeded;
                        unique case (t_action'(s_axis_tuser))
                            ACT_RESEED: begin
                                r_a     <= '0;
                                r_b     <= '0;
                                r_cnt   <= '0;
                                r_v     <= INIT_V;
                                r_base  <= '0;
                                r_pass  <= 1'b0;
                                r_k     <= '0;
                                r_state <= S_LOAD;
                            end
                            ACT_RAW, ACT_RANGE: begin
                                priority if (!r_seeded) begin
                                    r_w     <= '0;
                                    r_state <= S_RESULT;
                                end else if (r_rem == '0) begin
                                    r_cnt   <= r_cnt + 32'd1;
                                    r_b     <= r_b + r_cnt + 32'd1;
                                    r_i     <= '0;
                                    r_ph    <= '0;
                                    r_state <= S_BATCH;
                                end else begin
                                    r_rem   <= r_rem - 1'b1;
                                    r_state <= S_DRAW_RD;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // Add seed words (first pass) or pool words (second pass)
                S_LOAD: begin
                    if (!r_pass) begin
                        for (int k = 0; k < 8; k++) begin
                            r_v[k] <= r_v[k] + r_seed + 32'(r_base) + 32'(k);
                        end
                        r_k     <= '0;
                        r_state <= S_MIX;
                    end else begin
                        if (r_k != 4'd0) begin
                            r_v[3'(r_k - 4'd1)] <= r_v[3'(r_k - 4'd1)] + r_pool_q;
                        end
                        if (r_k == 4'd8) begin
                            r_k     <= '0;
                            r_state <= S_MIX;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                // One scramble line per cycle
                S_MIX: begin
                    r_v <= scramble_step(r_v, r_k[2:0]);
                    if (r_k == 4'd7) begin
                        r_k     <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                // Store the group back into the pool
                S_WRITE: begin
                    if (r_k == 4'd7) begin
                        r_k    <= '0;
                        r_base <= r_base + L'(8);
                        if (r_base == L'(N - 8)) begin
                            if (!r_pass) begin
                                r_pass  <= 1'b1;
                                r_state <= S_LOAD;
                            end else begin
                                r_cnt   <= r_cnt + 32'd1;
                                r_b     <= r_b + r_cnt + 32'd1;
                                r_i     <= '0;
                                r_ph    <= '0;
                                r_state <= S_BATCH;
                            end
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                // Five-phase ISAAC step per pool word
                S_BATCH: begin
                    unique case (r_ph)
                        3'd0: begin
                            r_a  <= n_amix;
                            r_ph <= 3'd1;
                        end
                        3'd1: begin
                            r_x  <= r_pool_q;
                            r_ph <= 3'd2;
                        end
                        3'd2: begin
                            r_a  <= r_a + r_pool_q;
                            r_ph <= 3'd3;
                        end
                        3'd3: begin
                            r_y   <= n_y;
                            r_fwd <= (y_idx == r_i);
                            r_ph  <= 3'd4;
                        end
                        default: begin
                            r_b  <= n_b;
                            r_ph <= 3'd0;
                            r_i  <= r_i + 1'b1;
                            if (&r_i) begin
                                if (r_act == ACT_RESEED) begin
                                    r_rem    <= (L+1)'(N);
                                    r_seeded <= 1'b1;
                                    r_state  <= S_IDLE;
                                end else begin
                                    r_rem   <= (L+1)'(N - 1);
                                    r_state <= S_DRAW_RD;
                                end
                            end
                        end
                    endcase
                end
                S_DRAW_RD: begin
                    r_state <= S_DRAW_DATA;
                end
                S_DRAW_DATA: begin
                    r_w     <= r_rbuf_q;
                    r_state <= (r_act == ACT_RANGE) ? S_FOLD : S_RESULT;
                end
                // Handle empty and full ranges; otherwise latch the span for the fold
                S_FOLD: begin
                    priority if (r_lo >= r_hi) begin
                        r_w     <= r_hi;
                        r_state <= S_RESULT;
                    end else if (n_span == '0) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_span  <= n_span;
                        r_state <= S_FCHK;
                    end
                end
                S_FCHK: begin
                    if (r_w < r_span) begin
                        r_w     <= r_w + r_lo;
                        r_state <= S_RESULT;
                    end else begin
                        r_dv    <= r_w;
                        r_q     <= '0;
                        r_r     <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                // Restoring division, one quotient bit per cycle
                S_DIV: begin
                    r_dv <= r_dv << 1;
                    if (div_rr >= {1'b0, r_span}) begin
                        r_r <= 32'(div_rr - {1'b0, r_span});
                        r_q <= {r_q[30:0], 1'b1};
                    end else begin
                        r_r <= div_rr[31:0];
                        r_q <= {r_q[30:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= S_FCHK;
                    end
                end
                S_RESULT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oword  <= r_w;
                        r_ons    <= r_ns;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Fold quotient and remainder once the divider finishes
            if (r_state == S_DIV && r_dcnt == 5'd31) begin
                r_w <= {r_q[30:0], (div_rr >= {1'b0, r_span})}
                       ^ ((div_rr >= {1'b0, r_span}) ?
                          32'(div_rr - {1'b0, r_span}) : div_rr[31:0]);
            end
        end
    end

endmodule
